FILE: hdl/qsfd_pkg.sv
// ----------------------------------------------------------------------------
// qsfd_pkg: shared types and constants for the query string form decoder
// Holds the payload structs, the classified byte record, the error codes and
// the state encodings used by the front, the queue and the back.
// ----------------------------------------------------------------------------
package qsfd_pkg;

   localparam int MAX_PAIRS_DEFAULT = 32;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;   // '+'
   localparam logic [7:0] CHAR_PERCENT = 8'h25;   // '%'
   localparam logic [7:0] CHAR_AMP     = 8'h26;   // '&'
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;   // '='
   localparam logic [7:0] CHAR_SPACE   = 8'h20;   // ' '
   localparam logic [7:0] CTRL_LIMIT   = 8'h20;   // below this is a control byte
   localparam logic [7:0] CHAR_DEL     = 8'h7F;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_BAD_ESCAPE = 2'd1,
      ERR_TOO_MANY   = 2'd2
   } error_type;

   typedef enum logic [3:0] {
      MODE_START = 4'b0001,
      MODE_NAME  = 4'b0010,
      MODE_VALUE = 4'b0100,
      MODE_SKIP  = 4'b1000
   } pair_mode_type;

   typedef enum logic [2:0] {
      ESC_NONE = 3'b001,
      ESC_HIGH = 3'b010,
      ESC_LOW  = 3'b100
   } escape_type;

   typedef struct packed {
      logic [7:0] query_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] decoded_byte;
      logic       in_value;
      logic       pair_done;
      logic [1:0] error_code;
      logic       query_done;
   } rsp_type;

   // One raw byte with its class worked out by the front
   typedef struct packed {
      logic [7:0] raw_byte;
      logic       is_last;
      logic       is_hex;
      logic [3:0] digit_nibble;
      logic       is_plus;
      logic       is_percent;
      logic       is_amp;
      logic       is_equal;
   } class_type;

endpackage

FILE: hdl/qsfd_front.sv
// ----------------------------------------------------------------------------
// qsfd_front: byte classifier
// Tags each incoming raw byte with its hex digit value and its separator and
// escape classes so the back only has to walk the pair state machine.
// ----------------------------------------------------------------------------
module qsfd_front (
   input  qsfd_pkg::req_type   req_data,
   output qsfd_pkg::class_type class_data
);

   logic [7:0] b;

   assign b = req_data.query_byte;

   always_comb begin
      class_data            = '0;
      class_data.raw_byte   = b;
      class_data.is_last    = req_data.is_last;
      class_data.is_plus    = (b == qsfd_pkg::CHAR_PLUS);
      class_data.is_percent = (b == qsfd_pkg::CHAR_PERCENT);
      class_data.is_amp     = (b == qsfd_pkg::CHAR_AMP);
      class_data.is_equal   = (b == qsfd_pkg::CHAR_EQUAL);
      // decimal digits, then lower and upper case hex letters
      if (b >= 8'h30 && b <= 8'h39) begin
         class_data.is_hex       = 1'b1;
         class_data.digit_nibble = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         class_data.is_hex       = 1'b1;
         class_data.digit_nibble = b[3:0] + 4'd9;
      end
   end

endmodule

FILE: hdl/qsfd_queue.sv
// ----------------------------------------------------------------------------
// qsfd_queue: two-entry queue between front and back
// Decouples the input stall from the back so either side can hold on its own.
// ----------------------------------------------------------------------------
module qsfd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qsfd_pkg::class_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output qsfd_pkg::class_type head_data
);

   logic [1:0]          count_ff, count_in;
   qsfd_pkg::class_type slot0_ff, slot0_in;
   qsfd_pkg::class_type slot1_ff, slot1_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = slot0_ff;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      priority if (push && pop) begin
         // count stays; advance the head and append
         if (count_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end else if (push) begin
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

FILE: hdl/qsfd_back.sv
// ----------------------------------------------------------------------------
// qsfd_back: pair and escape state machine with result register
// Walks name/value pairs, decodes escapes, counts pairs and latches errors;
// one classified byte per cycle into a registered result while not stalled.
// ----------------------------------------------------------------------------
module qsfd_back #(
   parameter int MAX_PAIRS = qsfd_pkg::MAX_PAIRS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  qsfd_pkg::class_type head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output qsfd_pkg::rsp_type   rsp_data
);

   localparam int CountWidth = $clog2(MAX_PAIRS + 1);
   localparam logic [CountWidth-1:0] PairLimit = CountWidth'(MAX_PAIRS);

   qsfd_pkg::pair_mode_type mode_ff, mode_in;
   qsfd_pkg::escape_type    esc_ff, esc_in;
   logic [3:0]              nibble_ff, nibble_in;
   logic [CountWidth-1:0]   pairs_ff, pairs_in;
   logic                    err_latched_ff, err_latched_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   qsfd_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   qsfd_pkg::error_type     err;
   qsfd_pkg::rsp_type       result;
   logic [7:0]              decoded;
   logic                    component;

   assign pop       = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign decoded   = {nibble_ff, head_data.digit_nibble};

   always_comb begin
      mode_in        = mode_ff;
      esc_in         = esc_ff;
      nibble_in      = nibble_ff;
      pairs_in       = pairs_ff;
      err_latched_in = err_latched_ff;
      err            = qsfd_pkg::ERR_NONE;
      result         = '0;
      component      = 1'b0;

      if (!err_latched_ff) begin
         if (esc_ff != qsfd_pkg::ESC_NONE) begin
            if (!head_data.is_hex) begin
               err = qsfd_pkg::ERR_BAD_ESCAPE;
            end else if (esc_ff == qsfd_pkg::ESC_HIGH) begin
               nibble_in = head_data.digit_nibble;
               esc_in    = qsfd_pkg::ESC_LOW;
            end else begin
               esc_in = qsfd_pkg::ESC_NONE;
               if (decoded < qsfd_pkg::CTRL_LIMIT || decoded == qsfd_pkg::CHAR_DEL) begin
                  err = qsfd_pkg::ERR_BAD_ESCAPE;
               end else begin
                  result.byte_valid   = 1'b1;
                  result.decoded_byte = decoded;
                  result.in_value     = (mode_ff == qsfd_pkg::MODE_VALUE);
               end
            end
         end else begin
            unique case (mode_ff)
               qsfd_pkg::MODE_START: begin
                  if (head_data.is_equal) begin
                     mode_in = qsfd_pkg::MODE_SKIP;
                  end else if (!head_data.is_amp) begin
                     if (pairs_ff >= PairLimit) begin
                        err = qsfd_pkg::ERR_TOO_MANY;
                     end else begin
                        mode_in   = qsfd_pkg::MODE_NAME;
                        component = 1'b1;
                     end
                  end
               end
               qsfd_pkg::MODE_NAME: begin
                  if (head_data.is_amp) begin
                     result.pair_done = 1'b1;
                     pairs_in         = pairs_ff + 1'b1;
                     mode_in          = qsfd_pkg::MODE_START;
                  end else if (head_data.is_equal) begin
                     mode_in = qsfd_pkg::MODE_VALUE;
                  end else begin
                     component = 1'b1;
                  end
               end
               qsfd_pkg::MODE_VALUE: begin
                  if (head_data.is_amp) begin
                     result.pair_done = 1'b1;
                     pairs_in         = pairs_ff + 1'b1;
                     mode_in          = qsfd_pkg::MODE_START;
                  end else begin
                     component = 1'b1;
                  end
               end
               qsfd_pkg::MODE_SKIP: begin
                  if (head_data.is_amp) begin
                     mode_in = qsfd_pkg::MODE_START;
                  end
               end
               default: begin
                  mode_in = qsfd_pkg::MODE_START;
               end
            endcase
            if (component) begin
               if (head_data.is_percent) begin
                  esc_in = qsfd_pkg::ESC_HIGH;
               end else begin
                  result.byte_valid   = 1'b1;
                  result.decoded_byte = head_data.is_plus ? qsfd_pkg::CHAR_SPACE
                                                          : head_data.raw_byte;
                  result.in_value     = (mode_in == qsfd_pkg::MODE_VALUE);
               end
            end
         end

         // close an open pair or flag a cut-off escape on the last byte
         if (err == qsfd_pkg::ERR_NONE && head_data.is_last) begin
            if (esc_in != qsfd_pkg::ESC_NONE) begin
               err = qsfd_pkg::ERR_BAD_ESCAPE;
            end else if (mode_in == qsfd_pkg::MODE_NAME || mode_in == qsfd_pkg::MODE_VALUE) begin
               result.pair_done = 1'b1;
            end
         end
         if (err != qsfd_pkg::ERR_NONE) begin
            err_latched_in   = 1'b1;
            result.pair_done = 1'b0;
         end
      end

      result.error_code = err;
      result.query_done = head_data.is_last;

      if (head_data.is_last) begin
         mode_in        = qsfd_pkg::MODE_START;
         esc_in         = qsfd_pkg::ESC_NONE;
         nibble_in      = 4'd0;
         pairs_in       = '0;
         err_latched_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= qsfd_pkg::MODE_START;
         esc_ff         <= qsfd_pkg::ESC_NONE;
         nibble_ff      <= 4'd0;
         pairs_ff       <= '0;
         err_latched_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            mode_ff        <= mode_in;
            esc_ff         <= esc_in;
            nibble_ff      <= nibble_in;
            pairs_ff       <= pairs_in;
            err_latched_ff <= err_latched_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: hdl/query_string_form_decoder.sv
// ----------------------------------------------------------------------------
// query_string_form_decoder: streaming form-urlencoded query decoder
// Splits a query string into name/value pairs and percent-decodes them.
// ----------------------------------------------------------------------------
// Takes one raw query byte per transfer, with is_last on the final byte, and
// returns exactly one result per byte: the decoded byte tagged as name or
// value, a pair_done mark at '&' or end of query for each accepted pair, an
// error code on the byte that finds a bad, cut-off or control-byte escape or
// a pair beyond MAX_PAIRS, and query_done on the last byte. After an error the
// rest of the query gives no bytes; the last byte returns all state to reset.
// Throughput is one byte per clock unless rsp_stall holds the result: the
// classifier feeds a two-entry queue and the pair state machine consumes one
// queued byte per cycle into a result register. A byte passes from its queue
// entry to the result register and transfers from there while not stalled.
module query_string_form_decoder #(
   parameter int MAX_PAIRS = qsfd_pkg::MAX_PAIRS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qsfd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qsfd_pkg::rsp_type rsp_data
);

   qsfd_pkg::class_type class_data;
   qsfd_pkg::class_type head_data;
   logic                queue_full;
   logic                head_valid;
   logic                pop;

   // Classify the byte as it arrives
   qsfd_front u_front (
      .req_data   (req_data),
      .class_data (class_data)
   );

   // Hold classified bytes; stall the input only when both entries are taken
   qsfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !req_stall),
      .push_data  (class_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign req_stall = queue_full;

   // Advance the pair machine whenever the result register can take a result
   qsfd_back #(
      .MAX_PAIRS (MAX_PAIRS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
